/* rtl/dmsf_pkg.sv */
// Shared types, character codes and wrapper text tables of the marker stream filter.
`timescale 1ns / 1ps

package dmsf_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam logic [9:0] SplitLimitReset = 10'd512;

  localparam logic [7:0] CharCaret     = 8'h5E;
  localparam logic [7:0] CharLBracket  = 8'h5B;
  localparam logic [7:0] CharRBracket  = 8'h5D;
  localparam logic [7:0] CharLBrace    = 8'h7B;
  localparam logic [7:0] CharRBrace    = 8'h7D;
  localparam logic [7:0] CharLParen    = 8'h28;
  localparam logic [7:0] CharRParen    = 8'h29;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharSpace     = 8'h20;

  localparam logic [2:0] StOk             = 3'd0;
  localparam logic [2:0] StBadMarker      = 3'd1;
  localparam logic [2:0] StBadBlockMarker = 3'd2;
  localparam logic [2:0] StStrayText      = 3'd3;
  localparam logic [2:0] StStrUnterm      = 3'd4;
  localparam logic [2:0] StLineUnterm     = 3'd5;
  localparam logic [2:0] StUnterm         = 3'd6;

  typedef enum logic [2:0] {
    TxtCheck,
    TxtBlock,
    TxtSep,
    TxtClose,
    TxtDoc,
    TxtOpen,
    TxtSplit,
    TxtLineEnd
  } txt_id_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       has_text;
    txt_id_e    text_id;
    logic       has_char;
    logic [7:0] char_byte;
    logic       has_split;
  } cmd_t;

  typedef struct packed {
    logic [3:0] count;
    logic       has_status;
    logic [2:0] status;
  } grp_t;

  typedef struct packed {
    logic cmd_push;
    cmd_t cmd;
    logic grp_push;
    grp_t grp;
  } push_req_t;

  typedef struct packed {
    logic cmd_full;
    logic grp_full;
  } q_full_t;

  typedef struct packed {
    logic cmd_valid;
    cmd_t cmd;
    logic grp_valid;
    grp_t grp;
  } deq_view_t;

  typedef struct packed {
    logic cmd_pop;
    logic grp_pop;
  } deq_pop_t;

  localparam logic [103:0] StrCheck   = "(doc-check\n";
  localparam logic [103:0] StrBlock   = "(doc-block (\n";
  localparam logic [103:0] StrSep     = "\n)\n(\n";
  localparam logic [103:0] StrClose   = "))\n";
  localparam logic [103:0] StrDoc     = "docstring\n";
  localparam logic [103:0] StrOpen    = "\nstring ";
  localparam logic [103:0] StrSplit   = "\"\nstring \"";
  localparam logic [103:0] StrLineEnd = "\n)\n";

  function automatic logic [3:0] txt_len(txt_id_e id);
    logic [3:0] n;
    case (id)
      TxtCheck:   n = 4'd11;
      TxtBlock:   n = 4'd13;
      TxtSep:     n = 4'd5;
      TxtClose:   n = 4'd3;
      TxtDoc:     n = 4'd10;
      TxtOpen:    n = 4'd8;
      TxtSplit:   n = 4'd10;
      TxtLineEnd: n = 4'd3;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [103:0] txt_str(txt_id_e id);
    logic [103:0] s;
    case (id)
      TxtCheck:   s = StrCheck;
      TxtBlock:   s = StrBlock;
      TxtSep:     s = StrSep;
      TxtClose:   s = StrClose;
      TxtDoc:     s = StrDoc;
      TxtOpen:    s = StrOpen;
      TxtSplit:   s = StrSplit;
      TxtLineEnd: s = StrLineEnd;
      default:    s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] txt_char(txt_id_e id, logic [3:0] idx);
    logic [103:0] s;
    logic [3:0]   pos;
    s   = txt_str(id);
    pos = txt_len(id) - 4'd1 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/dmsf_fifo.sv */
// Small first-in first-out queue of packed words between the front and back parts.
`timescale 1ns / 1ps

module dmsf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = dmsf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));

endmodule

/* rtl/dmsf_front.sv */
// Front part: parses input bytes, holds the split limit and queues emit commands and groups.
`timescale 1ns / 1ps

module dmsf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dmsf_pkg::in_item_t  in_data_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [9:0]          cfg_data_i,
  input  dmsf_pkg::q_full_t   q_full_i,
  output dmsf_pkg::push_req_t push_o
);

  localparam logic [3:0] SSkip      = 4'd0;
  localparam logic [3:0] SSkipMark  = 4'd1;
  localparam logic [3:0] SBlock     = 4'd2;
  localparam logic [3:0] SBlockMark = 4'd3;
  localparam logic [3:0] SStrDrop   = 4'd4;
  localparam logic [3:0] SStrSkip   = 4'd5;
  localparam logic [3:0] SStrIn     = 4'd6;
  localparam logic [3:0] SStrEsc    = 4'd7;
  localparam logic [3:0] SStrExit   = 4'd8;
  localparam logic [3:0] SLineDrop  = 4'd9;
  localparam logic [3:0] SLineBody  = 4'd10;
  localparam logic [3:0] SHalt      = 4'd11;

  logic [3:0]  state_q, state_d;
  logic        cookie_q, cookie_d;
  logic [10:0] chunk_q, chunk_d;
  logic [2:0]  wait_q, wait_d;
  logic [9:0]  split_limit_q;

  logic [7:0]     c;
  logic           accept;
  logic [10:0]    chunk_n;
  logic           split_n;
  logic           has_status;
  logic [2:0]     status;
  dmsf_pkg::cmd_t cmd;
  logic [4:0]     pushed;
  logic [4:0]     total;
  logic [4:0]     room;
  logic [4:0]     emit;

  assign c           = in_data_i.in_byte;
  assign in_stall_o  = q_full_i.cmd_full || q_full_i.grp_full;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    cookie_d   = cookie_q;
    chunk_d    = chunk_q;
    cmd        = '0;
    has_status = 1'b0;
    status     = dmsf_pkg::StOk;
    chunk_n    = chunk_q + 11'd1;
    split_n    = (chunk_n >= {1'b0, split_limit_q});

    if (state_q != SHalt) begin
      if (in_data_i.end_of_input) begin
        has_status = 1'b1;
        case (state_q)
          SSkip:                      status = dmsf_pkg::StOk;
          SStrSkip, SStrIn, SStrEsc:  status = dmsf_pkg::StStrUnterm;
          SLineBody:                  status = dmsf_pkg::StLineUnterm;
          default:                    status = dmsf_pkg::StUnterm;
        endcase
      end else begin
        case (state_q)
          SSkip: begin
            if (c == dmsf_pkg::CharCaret) begin
              if (cookie_q) begin
                state_d  = SSkipMark;
                cookie_d = 1'b0;
              end else begin
                cookie_d = 1'b1;
              end
            end else if (c != dmsf_pkg::CharSpace) begin
              cookie_d = 1'b0;
            end
          end
          SSkipMark: begin
            if (c == dmsf_pkg::CharLBracket) begin
              cmd.has_text = 1'b1;
              cmd.text_id  = dmsf_pkg::TxtCheck;
              state_d      = SLineDrop;
            end else if (c == dmsf_pkg::CharLBrace) begin
              cmd.has_text = 1'b1;
              cmd.text_id  = dmsf_pkg::TxtBlock;
              state_d      = SBlock;
            end else begin
              has_status = 1'b1;
              status     = dmsf_pkg::StBadMarker;
            end
          end
          SBlock: begin
            if (c == dmsf_pkg::CharCaret) begin
              if (cookie_q) begin
                cmd.has_text = 1'b1;
                cmd.text_id  = dmsf_pkg::TxtSep;
                state_d      = SBlockMark;
                cookie_d     = 1'b0;
              end else begin
                cookie_d = 1'b1;
              end
            end else begin
              if (c != dmsf_pkg::CharSpace) begin
                cookie_d = 1'b0;
              end
              cmd.has_char  = 1'b1;
              cmd.char_byte = c;
            end
          end
          SBlockMark: begin
            if (c == dmsf_pkg::CharLParen) begin
              state_d = SStrDrop;
            end else if (c == dmsf_pkg::CharSpace) begin
              state_d = SBlock;
            end else if (c == dmsf_pkg::CharRBrace) begin
              cmd.has_text = 1'b1;
              cmd.text_id  = dmsf_pkg::TxtClose;
              state_d      = SSkip;
            end else begin
              has_status = 1'b1;
              status     = dmsf_pkg::StBadBlockMarker;
            end
          end
          SStrDrop: begin
            cmd.has_text = 1'b1;
            cmd.text_id  = dmsf_pkg::TxtDoc;
            chunk_d      = '0;
            state_d      = SStrSkip;
          end
          SStrSkip: begin
            if (c == dmsf_pkg::CharQuote) begin
              cmd.has_text  = 1'b1;
              cmd.text_id   = dmsf_pkg::TxtOpen;
              cmd.has_char  = 1'b1;
              cmd.char_byte = c;
              cmd.has_split = (split_limit_q <= 10'd1);
              chunk_d       = cmd.has_split ? 11'd0 : 11'd1;
              state_d       = SStrIn;
            end else if (c == dmsf_pkg::CharRParen) begin
              state_d = SStrExit;
            end else if (!(c inside {8'h20, [8'h09:8'h0D]})) begin
              has_status = 1'b1;
              status     = dmsf_pkg::StStrayText;
            end
          end
          SStrIn: begin
            cmd.has_char  = 1'b1;
            cmd.char_byte = c;
            if (c == dmsf_pkg::CharBackslash) begin
              chunk_d = chunk_n;
              state_d = SStrEsc;
            end else if (c == dmsf_pkg::CharQuote) begin
              state_d = SStrSkip;
            end else begin
              cmd.has_split = split_n;
              chunk_d       = split_n ? 11'd0 : chunk_n;
            end
          end
          SStrEsc: begin
            cmd.has_char  = 1'b1;
            cmd.char_byte = c;
            cmd.has_split = split_n;
            chunk_d       = split_n ? 11'd0 : chunk_n;
            state_d       = SStrIn;
          end
          SStrExit: state_d = SBlock;
          SLineDrop: state_d = SLineBody;
          SLineBody: begin
            if (c == dmsf_pkg::CharRBracket) begin
              cmd.has_text = 1'b1;
              cmd.text_id  = dmsf_pkg::TxtLineEnd;
              state_d      = SSkip;
            end else begin
              cmd.has_char  = 1'b1;
              cmd.char_byte = c;
            end
          end
          default: state_d = state_q;
        endcase
      end
      if (has_status) begin
        state_d = SHalt;
      end
    end

    pushed = (cmd.has_text ? {1'b0, dmsf_pkg::txt_len(cmd.text_id)} : 5'd0)
           + {4'd0, cmd.has_char}
           + (cmd.has_split ? {1'b0, dmsf_pkg::txt_len(dmsf_pkg::TxtSplit)} : 5'd0);
    total  = {2'b00, wait_q} + pushed;
    room   = has_status ? 5'd11 : 5'd12;
    emit   = (total < room) ? total : room;
    wait_d = 3'(total - emit);
  end

  always_comb begin
    push_o.cmd_push       = accept && (pushed != 5'd0);
    push_o.cmd            = cmd;
    push_o.grp_push       = accept && ((emit != 5'd0) || has_status);
    push_o.grp.count      = emit[3:0];
    push_o.grp.has_status = has_status;
    push_o.grp.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SSkip;
      cookie_q      <= 1'b0;
      chunk_q       <= '0;
      wait_q        <= '0;
      split_limit_q <= dmsf_pkg::SplitLimitReset;
    end else begin
      if (accept) begin
        state_q  <= state_d;
        cookie_q <= cookie_d;
        chunk_q  <= chunk_d;
        wait_q   <= wait_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        split_limit_q <= cfg_data_i;
      end
    end
  end

endmodule

/* rtl/dmsf_back.sv */
// Back part: expands queued commands into bytes, groups them and drives the output register.
`timescale 1ns / 1ps

module dmsf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmsf_pkg::deq_view_t deq_i,
  output dmsf_pkg::deq_pop_t  pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmsf_pkg::out_item_t out_data_o
);

  localparam logic [1:0] PhText  = 2'd0;
  localparam logic [1:0] PhChar  = 2'd1;
  localparam logic [1:0] PhSplit = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] sent_q, sent_d;
  logic       out_valid_q;
  dmsf_pkg::out_item_t out_q;

  logic [1:0]          eff;
  dmsf_pkg::txt_id_e   cur_txt;
  logic [7:0]          cur_byte;
  logic                idx_last;
  logic                done;
  logic                load;
  logic                bytes_left;
  logic                grp_last_byte;
  logic                fire_byte;
  logic                fire_status;
  dmsf_pkg::out_item_t item;

  always_comb begin
    if (phase_q == PhText && deq_i.cmd.has_text) begin
      eff = PhText;
    end else if (phase_q != PhSplit && deq_i.cmd.has_char) begin
      eff = PhChar;
    end else begin
      eff = PhSplit;
    end
    cur_txt  = (eff == PhSplit) ? dmsf_pkg::TxtSplit : deq_i.cmd.text_id;
    cur_byte = (eff == PhChar) ? deq_i.cmd.char_byte : dmsf_pkg::txt_char(cur_txt, idx_q);
    idx_last = (idx_q == dmsf_pkg::txt_len(cur_txt) - 4'd1);
    done = (eff == PhText && idx_last && !deq_i.cmd.has_char && !deq_i.cmd.has_split)
        || (eff == PhChar && !deq_i.cmd.has_split)
        || (eff == PhSplit && idx_last);

    load          = !out_valid_q || !out_stall_i;
    bytes_left    = (sent_q != deq_i.grp.count);
    grp_last_byte = (sent_q + 4'd1 == deq_i.grp.count);
    fire_byte     = load && deq_i.grp_valid && bytes_left && deq_i.cmd_valid;
    fire_status   = load && deq_i.grp_valid && !bytes_left;

    pop_o.cmd_pop = fire_byte && done;
    pop_o.grp_pop = (fire_byte && grp_last_byte && !deq_i.grp.has_status) || fire_status;

    if (done) begin
      phase_d = PhText;
      idx_d   = '0;
    end else if (eff == PhText && idx_last) begin
      phase_d = PhChar;
      idx_d   = '0;
    end else if (eff == PhChar) begin
      phase_d = PhSplit;
      idx_d   = '0;
    end else begin
      phase_d = eff;
      idx_d   = idx_q + 4'd1;
    end

    if (pop_o.grp_pop) begin
      sent_d = '0;
    end else if (fire_byte) begin
      sent_d = sent_q + 4'd1;
    end else begin
      sent_d = sent_q;
    end

    if (fire_status) begin
      item.out_byte   = 8'd0;
      item.byte_valid = 1'b0;
      item.status     = deq_i.grp.status;
      item.last       = 1'b1;
    end else begin
      item.out_byte   = cur_byte;
      item.byte_valid = 1'b1;
      item.status     = dmsf_pkg::StOk;
      item.last       = grp_last_byte && !deq_i.grp.has_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhText;
      idx_q       <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_byte) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
      end
      sent_q <= sent_d;
      if (load) begin
        out_valid_q <= fire_byte || fire_status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_byte || fire_status) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/doc_marker_stream_filter_top.sv */
// Top level of the marker stream filter: front parser, cmd and grp queues and back emitter.
// The first result of an input transfer passes the queues and then the output register.
// Throughput: one input transfer per cycle while each causes at most one output byte and
// out_stall_i is low. Wrapper text leaves at one byte per cycle while out_stall_i is low.
// Reset is asynchronous and active low; it restores the split limit of 512 and empties all
// queues, with no clearing pass. Input stalls once a queue of QueueDepth fills.
`timescale 1ns / 1ps

module doc_marker_stream_filter_top #(
  parameter int unsigned QueueDepth = dmsf_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dmsf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmsf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [9:0]          cfg_data_i
);

  localparam int unsigned CmdW = $bits(dmsf_pkg::cmd_t);
  localparam int unsigned GrpW = $bits(dmsf_pkg::grp_t);

  dmsf_pkg::push_req_t push;
  dmsf_pkg::q_full_t   q_full;
  dmsf_pkg::deq_view_t deq;
  dmsf_pkg::deq_pop_t  pop;
  logic [CmdW-1:0]     cmd_head;
  logic [GrpW-1:0]     grp_head;

  dmsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  dmsf_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.cmd_push),
    .data_i  (push.cmd),
    .pop_i   (pop.cmd_pop),
    .data_o  (cmd_head),
    .valid_o (deq.cmd_valid),
    .full_o  (q_full.cmd_full)
  );

  dmsf_fifo #(
    .Width (GrpW),
    .Depth (QueueDepth)
  ) u_grp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push.grp_push),
    .data_i  (push.grp),
    .pop_i   (pop.grp_pop),
    .data_o  (grp_head),
    .valid_o (deq.grp_valid),
    .full_o  (q_full.grp_full)
  );

  assign deq.cmd = dmsf_pkg::cmd_t'(cmd_head);
  assign deq.grp = dmsf_pkg::grp_t'(grp_head);

  dmsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_i       (deq),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/dmsf_checker.sv */
// Port-level checker of the marker stream filter and its bind to the top level.
`timescale 1ns / 1ps

module dmsf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dmsf_pkg::out_item_t out_data_o
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output valid dropped while stalled.");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last)
    else $error("Status result is not marked last.");

  a_byte_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.status == dmsf_pkg::StOk)
    else $error("Character result carries a nonzero status.");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'd0)
    else $error("Status result carries a nonzero byte.");

  a_quiet_after_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.byte_valid |=> !out_valid_o)
    else $error("Output continued after the status transfer.");

endmodule

bind doc_marker_stream_filter_top dmsf_checker u_dmsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
